@@ design/dltq_pkg.sv @@
// ----------------------------------------------------------------------------
// Delta list timeout queue package
// Shared types and codes for the timeout queue and its list cells.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int unsigned ListDepthDefault = 16;
  localparam int unsigned MaxResults       = 16;
  localparam int unsigned ResCntW          = $clog2(MaxResults + 1);
  localparam int unsigned DeltaW           = 24;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_SCHEDULE   = 2'd0;
  localparam logic [1:0] OP_UNSCHEDULE = 2'd1;
  localparam logic [1:0] OP_TICK       = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_SCHEDULED = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_REMOVED   = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [2:0] KIND_EXPIRED   = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] timeout_id;
    logic [7:0]  owner_id;
    logic [23:0] interval;
  } dltq_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] expired_id;
    logic [7:0]  expired_owner;
    logic        any_expired;
    logic        last;
  } dltq_out_t;

  // Command broadcast to every cell.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_POP,
    CMD_TICK
  } dltq_cmd_e;

  typedef struct packed {
    logic              valid;
    logic [DeltaW-1:0] delta;
    logic [15:0]       id;
    logic [7:0]        owner;
  } dltq_entry_t;

  typedef struct packed {
    dltq_cmd_e         cmd;
    logic [15:0]       id;
    logic [7:0]        owner;
    logic [DeltaW-1:0] interval;
    logic [15:0]       tick;
  } dltq_bcast_t;

  // Link from one cell to the cell behind it.
  typedef struct packed {
    dltq_entry_t       entry;
    logic [DeltaW-1:0] due;
    logic              after;
    logic              ins;
    logic              hit_seen;
  } dltq_fwd_t;

endpackage

@@ design/dltq_cell.sv @@
// ----------------------------------------------------------------------------
// Delta list cell
// Holds one list entry and its running due time, and updates itself from
// its neighbors on insert, remove, pop and tick commands.
// ----------------------------------------------------------------------------
module dltq_cell
  import dltq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_i,
  input  dltq_bcast_t bcast_i,
  input  dltq_fwd_t   prev_i,
  input  dltq_entry_t next_i,
  output dltq_fwd_t   fwd_o,
  output dltq_entry_t entry_o
);

  logic              valid_q, valid_d;
  logic [DeltaW-1:0] delta_q, delta_d;
  logic [15:0]       id_q, id_d;
  logic [7:0]        owner_q, owner_d;
  logic [DeltaW-1:0] due_q, due_d;

  logic match, first, hit_seen, after, ins;

  // Local flags for search and insert position.
  always_comb begin
    match    = valid_q && (id_q == bcast_i.id) && (owner_q == bcast_i.owner);
    hit_seen = prev_i.hit_seen | match;
    first    = match & ~prev_i.hit_seen;
    after    = ~valid_q | (due_q > bcast_i.interval);
    ins      = after & ~prev_i.after;
  end

  assign entry_o = '{valid: valid_q, delta: delta_q, id: id_q, owner: owner_q};
  assign fwd_o   = '{entry: entry_o, due: due_q, after: after, ins: ins,
                     hit_seen: hit_seen};

  // Next entry contents.
  always_comb begin
    valid_d = valid_q;
    delta_d = delta_q;
    id_d    = id_q;
    owner_d = owner_q;
    due_d   = prev_i.due + delta_q;
    unique case (bcast_i.cmd)
      CMD_HOLD: begin
      end
      CMD_INSERT: begin
        if (ins) begin
          valid_d = 1'b1;
          delta_d = bcast_i.interval - prev_i.due;
          id_d    = bcast_i.id;
          owner_d = bcast_i.owner;
        end else if (prev_i.after) begin
          valid_d = prev_i.entry.valid;
          id_d    = prev_i.entry.id;
          owner_d = prev_i.entry.owner;
          delta_d = prev_i.ins ? (prev_i.due - bcast_i.interval) : prev_i.entry.delta;
        end
      end
      CMD_REMOVE: begin
        if (hit_seen) begin
          valid_d = next_i.valid;
          id_d    = next_i.id;
          owner_d = next_i.owner;
          delta_d = first ? (next_i.delta + delta_q) : next_i.delta;
        end
      end
      CMD_POP: begin
        valid_d = next_i.valid;
        id_d    = next_i.id;
        owner_d = next_i.owner;
        delta_d = next_i.delta;
      end
      CMD_TICK: begin
        if (head_i) begin
          if (delta_q <= DeltaW'(bcast_i.tick)) begin
            delta_d = '0;
          end else begin
            delta_d = delta_q - DeltaW'(bcast_i.tick);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Entry valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry payload and running due time.
  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    id_q    <= id_d;
    owner_q <= owner_d;
    due_q   <= due_d;
  end

endmodule

@@ design/delta_list_timeout_queue.sv @@
// ----------------------------------------------------------------------------
// Delta list timeout queue
// Bounded delta list of pending timeouts built as a row of list cells.
// ----------------------------------------------------------------------------
// Each cell keeps one entry and a running due time that ripples one cell per
// cycle down the row. After any change to the list the block passes through
// a settling state before it takes the next input transaction. A schedule
// that inserts, or an unschedule that removes, registers its result once the
// output is free and then settles. A tick on a non-empty list pops expired
// entries, with one result leaving per cycle while the output is not stalled,
// and then settles. A full list, no match, a tick on an empty list and an
// unknown operation return to idle without settling. Output stalls hold the
// block wherever a result has to wait.
module delta_list_timeout_queue
  import dltq_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = ListDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  dltq_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output dltq_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_SETTLE
  } state_e;

  state_e           state_q;
  dltq_in_t         op_q;
  logic [15:0]      tick_q;
  logic [CntW-1:0]  settle_q;
  logic [ResCntW-1:0] pop_q;
  logic             out_valid_q;
  dltq_out_t        out_q;

  dltq_bcast_t bcast;
  dltq_cmd_e   cmd;
  dltq_fwd_t   fwd  [LIST_DEPTH];
  dltq_entry_t ent  [LIST_DEPTH];

  logic out_free, full, found, pop_ok, more, out_load;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  assign full   = ent[LIST_DEPTH-1].valid;
  assign found  = fwd[LIST_DEPTH-1].hit_seen;
  assign pop_ok = ent[0].valid && (ent[0].delta == '0) &&
                  (pop_q < ResCntW'(MaxResults));
  assign more   = ent[1].valid && (ent[1].delta == '0) &&
                  ((pop_q + 1'b1) < ResCntW'(MaxResults));

  // A new result enters the output register in this cycle.
  assign out_load = out_free &&
                    (((state_q == ST_EXEC) &&
                      ((op_q.operation == OP_SCHEDULE) ||
                       (op_q.operation == OP_UNSCHEDULE))) ||
                     ((state_q == ST_POP) && pop_ok));

  // Command for the cell row.
  always_comb begin
    cmd = CMD_HOLD;
    if (state_q == ST_EXEC) begin
      unique case (op_q.operation)
        OP_SCHEDULE:   if (out_free && !full) cmd = CMD_INSERT;
        OP_UNSCHEDULE: if (out_free && found) cmd = CMD_REMOVE;
        OP_TICK:       if (ent[0].valid) cmd = CMD_TICK;
        default:       cmd = CMD_HOLD;
      endcase
    end else if (state_q == ST_POP) begin
      if (pop_ok && out_free) cmd = CMD_POP;
    end
  end

  assign bcast = '{cmd: cmd, id: op_q.timeout_id, owner: op_q.owner_id,
                   interval: op_q.interval, tick: tick_q};

  // Row of list cells.
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    dltq_fwd_t   prev;
    dltq_entry_t next;
    if (i == 0) begin : g_first
      assign prev = '0;
    end else begin : g_mid
      assign prev = fwd[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_end
      assign next = '0;
    end else begin : g_inner
      assign next = ent[i+1];
    end
    dltq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .head_i  (i == 0),
      .bcast_i (bcast),
      .prev_i  (prev),
      .next_i  (next),
      .fwd_o   (fwd[i]),
      .entry_o (ent[i])
    );
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= 16'd10;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tick_q <= cfg_data_i;
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      settle_q    <= '0;
      pop_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      op_q        <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q    <= in_data_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          settle_q <= CntW'(LIST_DEPTH);
          pop_q    <= '0;
          unique case (op_q.operation)
            OP_SCHEDULE: begin
              if (out_free) begin
                out_q <= '{kind: full ? KIND_FULL : KIND_SCHEDULED,
                           expired_id: '0, expired_owner: '0,
                           any_expired: 1'b0, last: 1'b1};
                state_q <= full ? ST_IDLE : ST_SETTLE;
              end
            end
            OP_UNSCHEDULE: begin
              if (out_free) begin
                out_q <= '{kind: found ? KIND_REMOVED : KIND_NOT_FOUND,
                           expired_id: '0, expired_owner: '0,
                           any_expired: 1'b0, last: 1'b1};
                state_q <= found ? ST_SETTLE : ST_IDLE;
              end
            end
            OP_TICK: state_q <= ent[0].valid ? ST_POP : ST_IDLE;
            default: state_q <= ST_IDLE;
          endcase
        end
        ST_POP: begin
          if (!pop_ok) begin
            state_q <= ST_SETTLE;
          end else if (out_free) begin
            out_q <= '{kind: KIND_EXPIRED, expired_id: ent[0].id,
                       expired_owner: ent[0].owner, any_expired: 1'b1,
                       last: ~more};
            pop_q <= pop_q + 1'b1;
          end
        end
        ST_SETTLE: begin
          if (settle_q == '0) begin
            state_q <= ST_IDLE;
          end else begin
            settle_q <= settle_q - 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ tb/delta_list_timeout_queue_test.sv @@
// ----------------------------------------------------------------------------
// Delta list timeout queue testbench
// Drives schedule, unschedule and tick transactions into the queue, predicts
// every result from an own model of the delta list, and checks each result
// field by field in order. The tick interval is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delta_list_timeout_queue_test;
  import dltq_pkg::*;

  localparam int unsigned Depth = ListDepthDefault;
  localparam int unsigned SettleCycles = 3 * Depth + 40;
  localparam int unsigned WatchLimit = 3000;
  localparam int unsigned HoldCycles = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  dltq_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  dltq_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // Stimulus state shared between the sequence and the driver.
  dltq_in_t  item_q[$];
  dltq_out_t result_q[$];
  int unsigned in_sent = 0;
  int unsigned in_acc = 0;
  logic      quiet = 1'b0;
  logic      hold_req = 1'b0;
  logic      hold_seen = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  int unsigned n_results = 0;
  int unsigned n_expired = 0;

  // Predicted list contents and tick interval.
  logic [31:0] list_delta[Depth];
  logic [15:0] list_id[Depth];
  logic [7:0]  list_owner[Depth];
  int unsigned list_count = 0;
  logic [15:0] tick_step = 16'd10;

  delta_list_timeout_queue u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  function automatic dltq_out_t status_result(logic [2:0] kind);
    dltq_out_t r;
    r = '0;
    r.kind = kind;
    r.last = 1'b1;
    return r;
  endfunction

  // Apply one accepted transaction to the predicted list and queue its results.
  task automatic predict_list_op(dltq_in_t t);
    logic [31:0] sum;
    logic [31:0] rel;
    int unsigned pos;
    int unsigned n;
    dltq_out_t r;
    logic hit;
    sum = '0;
    n = 0;
    hit = 1'b0;
    case (t.operation)
      OP_SCHEDULE: begin
        if (list_count >= Depth) begin
          result_q.push_back(status_result(KIND_FULL));
        end else begin
          pos = 0;
          while (pos < list_count && sum + list_delta[pos] <= {8'd0, t.interval}) begin
            sum = sum + list_delta[pos];
            pos++;
          end
          rel = {8'd0, t.interval} - sum;
          for (int i = list_count; i > pos; i--) begin
            list_delta[i] = list_delta[i-1];
            list_id[i] = list_id[i-1];
            list_owner[i] = list_owner[i-1];
          end
          list_delta[pos] = rel;
          list_id[pos] = t.timeout_id;
          list_owner[pos] = t.owner_id;
          list_count++;
          if (pos + 1 < list_count) list_delta[pos+1] = list_delta[pos+1] - rel;
          result_q.push_back(status_result(KIND_SCHEDULED));
        end
      end
      OP_UNSCHEDULE: begin
        for (int i = 0; i < list_count && !hit; i++) begin
          if (list_id[i] == t.timeout_id && list_owner[i] == t.owner_id) begin
            hit = 1'b1;
            rel = list_delta[i];
            for (int j = i; j + 1 < list_count; j++) begin
              list_delta[j] = list_delta[j+1];
              list_id[j] = list_id[j+1];
              list_owner[j] = list_owner[j+1];
            end
            list_count--;
            // Removing the tail moves no delay.
            if (i < list_count) list_delta[i] = list_delta[i] + rel;
          end
        end
        result_q.push_back(status_result(hit ? KIND_REMOVED : KIND_NOT_FOUND));
      end
      OP_TICK: begin
        if (list_count > 0) begin
          // Overshoot is dropped, not carried to later entries.
          if (list_delta[0] <= {16'd0, tick_step}) list_delta[0] = '0;
          else list_delta[0] = list_delta[0] - tick_step;
          while (list_count > 0 && list_delta[0] == 0 && n < MaxResults) begin
            r = '0;
            r.kind = KIND_EXPIRED;
            r.expired_id = list_id[0];
            r.expired_owner = list_owner[0];
            r.any_expired = 1'b1;
            for (int j = 0; j + 1 < list_count; j++) begin
              list_delta[j] = list_delta[j+1];
              list_id[j] = list_id[j+1];
              list_owner[j] = list_owner[j+1];
            end
            list_count--;
            n++;
            r.last = (list_count == 0 || list_delta[0] != 0 || n == MaxResults);
            result_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(dltq_out_t got);
    dltq_out_t exp_r;
    if (result_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %p", $time, got);
      errors++;
    end else begin
      exp_r = result_q[0];
      result_q.delete(0);
      if (got.kind !== exp_r.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
        errors++;
      end
      if (got.expired_id !== exp_r.expired_id) begin
        $display("%0t: expired_id expected %h actual %h", $time, exp_r.expired_id,
                 got.expired_id);
        errors++;
      end
      if (got.expired_owner !== exp_r.expired_owner) begin
        $display("%0t: expired_owner expected %h actual %h", $time,
                 exp_r.expired_owner, got.expired_owner);
        errors++;
      end
      if (got.any_expired !== exp_r.any_expired) begin
        $display("%0t: any_expired expected %b actual %b", $time, exp_r.any_expired,
                 got.any_expired);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $display("%0t: last expected %b actual %b", $time, exp_r.last, got.last);
        errors++;
      end
    end
  endtask

  // Monitor: take accepted transactions at the rising edge, watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (cfg_valid && cfg_ready) ||
          (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_valid && !in_stall) begin
        predict_list_op(in_data);
        in_acc <= in_acc + 1;
      end
      if (cfg_valid && cfg_ready) begin
        tick_step <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        check_result(out_data);
        n_results++;
        if (out_data.any_expired) n_expired++;
      end
      if (idle_cycles >= WatchLimit) begin
        $display("%0t: timeout, %0d results still expected", $time, result_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Driver: present the next pending transaction at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_acc == in_sent)) begin
      if (item_q.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
        in_data <= item_q[0];
        item_q.delete(0);
        in_valid <= 1'b1;
        in_sent <= in_sent + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cnt <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 9);
    end
  end

  function automatic dltq_in_t make_item(logic [1:0] op, logic [15:0] id,
                                         logic [7:0] owner, logic [23:0] iv);
    dltq_in_t t;
    t.operation = op;
    t.timeout_id = id;
    t.owner_id = owner;
    t.interval = iv;
    return t;
  endfunction

  // Mostly a small id pool so unschedules hit; sometimes full-width noise.
  task automatic add_random_items(int unsigned count);
    int unsigned sel;
    int unsigned pick;
    logic [1:0]  op;
    logic [15:0] id;
    logic [7:0]  owner;
    logic [23:0] iv;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) op = OP_SCHEDULE;
      else if (sel < 65) op = OP_UNSCHEDULE;
      else if (sel < 95) op = OP_TICK;
      else op = 2'd3;
      pick = $urandom_range(99);
      id = (pick < 80) ? 16'($urandom_range(7)) : 16'($urandom);
      owner = (pick < 80) ? 8'($urandom_range(3)) : 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 60) iv = 24'($urandom_range(50));
      else if (pick < 85) iv = 24'($urandom_range(2000));
      else iv = 24'($urandom);
      item_q.push_back(make_item(op, id, owner, iv));
    end
  endtask

  task automatic wait_drained();
    while (item_q.size() > 0 || (in_valid && in_acc != in_sent) || result_q.size() > 0)
      @(posedge clk_i);
    // Ignored items and ticks without expiries leave no result to wait for.
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_tick_step(logic [15:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty tick, unknown operation, extremes and removals.
    item_q.push_back(make_item(OP_TICK, 16'h0, 8'h0, 24'h0));
    item_q.push_back(make_item(2'd3, 16'hFFFF, 8'hFF, 24'hFFFFFF));
    item_q.push_back(make_item(OP_SCHEDULE, 16'hFFFF, 8'hFF, 24'hFFFFFF));
    item_q.push_back(make_item(OP_SCHEDULE, 16'h0, 8'h0, 24'h0));
    item_q.push_back(make_item(OP_SCHEDULE, 16'h1, 8'h1, 24'd5));
    item_q.push_back(make_item(OP_SCHEDULE, 16'h2, 8'h1, 24'd5));
    item_q.push_back(make_item(OP_UNSCHEDULE, 16'hFFFF, 8'hFF, 24'h0));
    item_q.push_back(make_item(OP_UNSCHEDULE, 16'h9, 8'h9, 24'h0));
    item_q.push_back(make_item(OP_UNSCHEDULE, 16'h1, 8'h1, 24'h0));
    item_q.push_back(make_item(OP_TICK, 16'h0, 8'h0, 24'h0));
    // Fill the list with due-now entries until it reports full.
    for (int i = 0; i < Depth + 1; i++)
      item_q.push_back(make_item(OP_SCHEDULE, 16'(16'h100 + i), 8'(i), 24'h0));
    item_q.push_back(make_item(OP_TICK, 16'h0, 8'h0, 24'h0));
    item_q.push_back(make_item(OP_TICK, 16'h0, 8'h0, 24'h0));

    write_tick_step(16'd1);
    add_random_items(90);

    // Long receiver hold-off while the sender keeps going.
    write_tick_step(16'hFFFF);
    hold_req <= 1'b1;
    add_random_items(80);

    write_tick_step(16'($urandom_range(1, 65535)));
    quiet <= 1'b1;
    add_random_items(80);
    wait_drained();
    quiet <= 1'b0;

    write_tick_step(16'd10);
    add_random_items(80);
    wait_drained();

    $display("Covered %0d transactions over four tick settings: %0d results, %0d expiries.",
             in_acc, n_results, n_expired);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
